FILE: hdl/assert_macros.svh
// Assertion macros shared by the icmp reply matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

FILE: hdl/icmp_rm_pkg.sv
// Types, constants and helpers for the icmp reply matcher.
package icmp_rm_pkg;

   localparam int IP_HDR_BYTES = 20;

   localparam int POS_W = 6;

   localparam logic [POS_W-1:0] ICMP_AT          = POS_W'(IP_HDR_BYTES);
   localparam logic [POS_W-1:0] ECHO_FIELDS_AT   = POS_W'(IP_HDR_BYTES + 4);
   localparam logic [POS_W-1:0] QUOTED_DEST_AT   = POS_W'(IP_HDR_BYTES + 8 + 16);
   localparam logic [POS_W-1:0] QUOTED_ICMP_AT   = POS_W'(IP_HDR_BYTES + 8 + IP_HDR_BYTES);
   localparam logic [POS_W-1:0] QUOTED_FIELDS_AT = POS_W'(IP_HDR_BYTES + 8 + IP_HDR_BYTES + 4);
   // last position index that still meets each minimum length
   localparam logic [POS_W-1:0] ECHO_LAST_MIN    = POS_W'(IP_HDR_BYTES + 8 - 1);
   localparam logic [POS_W-1:0] TE_LAST_MIN      = POS_W'(IP_HDR_BYTES + 8 + IP_HDR_BYTES + 8 - 1);
   localparam logic [POS_W-1:0] POS_MAX          = '1;

   localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
   localparam logic [7:0] TYPE_ECHO_REQUEST  = 8'd8;
   localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ADDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_ID    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_SEQ   = 2'd2;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] answered_addr;
   } req_payload_type;

   typedef struct packed {
      logic time_exceeded_match;
      logic echo_match;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] target_addr;
      logic [15:0] probe_id;
      logic [15:0] probe_seq;
   } cfg_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } result_beat_type;

   function automatic logic [7:0] probe_byte(cfg_type cfg, logic [1:0] k);
      logic [7:0] b;
      unique case (k)
         2'd0: b = cfg.probe_id[15:8];
         2'd1: b = cfg.probe_id[7:0];
         2'd2: b = cfg.probe_seq[15:8];
         default: b = cfg.probe_seq[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [7:0] target_byte(cfg_type cfg, logic [1:0] k);
      logic [7:0] b;
      unique case (k)
         2'd0: b = cfg.target_addr[31:24];
         2'd1: b = cfg.target_addr[23:16];
         2'd2: b = cfg.target_addr[15:8];
         default: b = cfg.target_addr[7:0];
      endcase
      return b;
   endfunction

endpackage

FILE: hdl/icmp_rm_tracker.sv
// Per-datagram byte tracking and match decision for the icmp reply matcher.
`include "assert_macros.svh"

module icmp_rm_tracker
   import icmp_rm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_payload_type req_data,
   input  cfg_type         cfg,
   output result_beat_type result
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       otype_ff, otype_in;
   logic             echo_ok_ff, echo_ok_in;
   logic             qdest_ok_ff, qdest_ok_in;
   logic             qtype_ok_ff, qtype_ok_in;
   logic             qfld_ok_ff, qfld_ok_in;

   logic [POS_W-1:0] off_echo, off_dest, off_qfld;
   logic             in_echo, in_dest, in_qfld;
   logic [7:0]       b;

   assign b        = req_data.data_byte;
   assign off_echo = pos_ff - ECHO_FIELDS_AT;
   assign off_dest = pos_ff - QUOTED_DEST_AT;
   assign off_qfld = pos_ff - QUOTED_FIELDS_AT;
   assign in_echo  = (pos_ff >= ECHO_FIELDS_AT) && (pos_ff < ECHO_FIELDS_AT + 6'd4);
   assign in_dest  = (pos_ff >= QUOTED_DEST_AT) && (pos_ff < QUOTED_DEST_AT + 6'd4);
   assign in_qfld  = (pos_ff >= QUOTED_FIELDS_AT) && (pos_ff < QUOTED_FIELDS_AT + 6'd4);

   always_comb begin
      otype_in    = (pos_ff == ICMP_AT) ? b : otype_ff;
      echo_ok_in  = echo_ok_ff && !(in_echo && (b != probe_byte(cfg, off_echo[1:0])));
      qdest_ok_in = qdest_ok_ff && !(in_dest && (b != target_byte(cfg, off_dest[1:0])));
      qtype_ok_in = qtype_ok_ff && !((pos_ff == QUOTED_ICMP_AT) && (b != TYPE_ECHO_REQUEST));
      qfld_ok_in  = qfld_ok_ff && !(in_qfld && (b != probe_byte(cfg, off_qfld[1:0])));
      pos_in      = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 6'd1;
   end

   always_comb begin
      result.valid = step && req_data.last_byte;
      result.data.time_exceeded_match = (otype_in == TYPE_TIME_EXCEEDED)
         && (pos_ff >= TE_LAST_MIN) && qdest_ok_in && qtype_ok_in && qfld_ok_in;
      result.data.echo_match = (otype_in == TYPE_ECHO_REPLY) && (pos_ff >= ECHO_LAST_MIN)
         && (req_data.answered_addr == cfg.target_addr) && echo_ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && req_data.last_byte)) begin
         pos_ff      <= '0;
         otype_ff    <= '0;
         echo_ok_ff  <= 1'b1;
         qdest_ok_ff <= 1'b1;
         qtype_ok_ff <= 1'b1;
         qfld_ok_ff  <= 1'b1;
      end else if (step) begin
         pos_ff      <= pos_in;
         otype_ff    <= otype_in;
         echo_ok_ff  <= echo_ok_in;
         qdest_ok_ff <= qdest_ok_in;
         qtype_ok_ff <= qtype_ok_in;
         qfld_ok_ff  <= qfld_ok_in;
      end
   end

   `ASSERT_ALWAYS(a_pos_clears_after_last, clock, reset,
                  step && req_data.last_byte |=> pos_ff == '0)
   `ASSERT_ALWAYS(a_pos_advances, clock, reset,
                  step && !req_data.last_byte && pos_ff != POS_MAX |=>
                  pos_ff == $past(pos_ff) + 6'd1)
   `ASSERT_ALWAYS(a_short_no_match, clock, reset,
                  pos_ff < ECHO_LAST_MIN |-> !result.data.echo_match &&
                  !result.data.time_exceeded_match)

endmodule

FILE: hdl/icmp_rm_out_reg.sv
// Result register between the decision logic and the response channel.
`include "assert_macros.svh"

module icmp_rm_out_reg
   import icmp_rm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  result_beat_type result,
   output logic            can_take,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic            valid_ff;
   rsp_payload_type data_ff;

   assign can_take  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_take) begin
         valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (can_take && result.valid) begin
         data_ff <= result.data;
      end
   end

   `ASSERT_NEVER(a_no_overwrite, clock, reset, result.valid && !can_take)
   `ASSERT_NEVER(a_single_kind, clock, reset,
                 valid_ff && data_ff.echo_match && data_ff.time_exceeded_match)
   `ASSERT_ALWAYS(a_stall_holds, clock, reset,
                  valid_ff && !rsp_ready |=> valid_ff && data_ff == $past(data_ff))

endmodule

FILE: hdl/icmp_reply_matcher.sv
// Top level of the icmp reply matcher: config registers, tracker and result register.
//
// Usage:
//   req_* carries one byte of a received IPv4 datagram per beat (20-byte IP
//   header), with last_byte set on the final byte and answered_addr valid
//   alongside it. Each datagram produces exactly one rsp_* beat, issued for
//   its last byte: time_exceeded_match or echo_match against the probe set
//   through csr_* (index 0 target_addr, 1 probe_id, 2 probe_seq).
//   Throughput: one byte per cycle while req_ready is high, set by the single
//   decision stage between the input beat and the result register.
//   Latency: the result beat is valid the cycle after the last byte is taken.
//   A stalled rsp_ready holds the result; req_ready then drops until the
//   result is taken, and resumes in the same cycle rsp_ready rises.
//   Reset clears the byte position, the pending result and all config registers
//   to zero, and sets the compare flags to one.
module icmp_reply_matcher
   import icmp_rm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type         cfg_ff;
   result_beat_type result;
   logic            step;

   assign step = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TARGET_ADDR: cfg_ff.target_addr <= csr_wdata;
            CSR_PROBE_ID:    cfg_ff.probe_id <= csr_wdata[15:0];
            CSR_PROBE_SEQ:   cfg_ff.probe_seq <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   icmp_rm_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .result   (result)
   );

   icmp_rm_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .can_take  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/icmp_reply_matcher_tb.sv
// Self-checking testbench for icmp_reply_matcher: byte-stream datagrams checked against a predictor.
module icmp_reply_matcher_tb
   import icmp_rm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ICMP_OFS     = 20;
   localparam int ECHO_ID_OFS  = 24;
   localparam int QDEST_OFS    = 44;
   localparam int QTYPE_OFS    = 48;
   localparam int QID_OFS      = 52;
   localparam int ECHO_MIN_LEN = 28;
   localparam int TE_MIN_LEN   = 56;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int SPOT[14]     = '{20, 24, 25, 26, 27, 44, 45, 46, 47, 48, 52, 53, 54, 55};

   typedef enum {FRAME_ECHO, FRAME_TIME_EXC, FRAME_NOISE} frame_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TARGET_ADDR;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state and its copy of the registers
   logic [5:0]  frame_pos;
   logic [7:0]  icmp_type_seen;
   bit          echo_ids_ok, qdest_ok, qtype_ok, qids_ok;
   logic [31:0] cfg_target = '0;
   logic [15:0] cfg_id = '0;
   logic [15:0] cfg_seq = '0;

   rsp_payload_type verdict_q[$];
   logic [7:0]      frame[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int errors = 0;
   int cycles = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int echo_hits = 0;
   int te_hits = 0;

   icmp_reply_matcher dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("icmp_reply_matcher_tb: errors");
         $finish;
      end
   end

   function automatic void clear_tracker();
      frame_pos = '0;
      icmp_type_seen = '0;
      echo_ids_ok = 1'b1;
      qdest_ok = 1'b1;
      qtype_ok = 1'b1;
      qids_ok = 1'b1;
   endfunction

   // advance the predictor by one accepted beat; queue a verdict on the last byte
   function automatic void track_byte(req_payload_type beat);
      int ofs;
      int len;
      logic [31:0] idseq;
      rsp_payload_type v;
      ofs = frame_pos;
      idseq = {cfg_id, cfg_seq};
      if (ofs == ICMP_OFS)
         icmp_type_seen = beat.data_byte;
      if (ofs >= ECHO_ID_OFS && ofs < ECHO_ID_OFS + 4 &&
          beat.data_byte != idseq[31 - 8 * (ofs - ECHO_ID_OFS) -: 8])
         echo_ids_ok = 1'b0;
      if (ofs >= QDEST_OFS && ofs < QDEST_OFS + 4 &&
          beat.data_byte != cfg_target[31 - 8 * (ofs - QDEST_OFS) -: 8])
         qdest_ok = 1'b0;
      if (ofs == QTYPE_OFS && beat.data_byte != TYPE_ECHO_REQUEST)
         qtype_ok = 1'b0;
      if (ofs >= QID_OFS && ofs < QID_OFS + 4 &&
          beat.data_byte != idseq[31 - 8 * (ofs - QID_OFS) -: 8])
         qids_ok = 1'b0;
      if (frame_pos != 6'h3f)
         frame_pos = frame_pos + 6'd1;
      if (beat.last_byte) begin
         len = ofs + 1;
         v = '0;
         v.time_exceeded_match = icmp_type_seen == TYPE_TIME_EXCEEDED && len >= TE_MIN_LEN &&
                                 qdest_ok && qtype_ok && qids_ok;
         v.echo_match = icmp_type_seen == TYPE_ECHO_REPLY && len >= ECHO_MIN_LEN &&
                        beat.answered_addr == cfg_target && echo_ids_ok;
         verdict_q.push_back(v);
         clear_tracker();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_data.echo_match) echo_hits++;
            if (rsp_data.time_exceeded_match) te_hits++;
            if (verdict_q.size() == 0) begin
               $error("unexpected result beat: time_exceeded_match %0b echo_match %0b",
                      rsp_data.time_exceeded_match, rsp_data.echo_match);
               errors++;
            end else begin
               rsp_payload_type want;
               want = verdict_q.pop_front();
               if (rsp_data.time_exceeded_match !== want.time_exceeded_match) begin
                  $error("time_exceeded_match: expected %0b, got %0b",
                         want.time_exceeded_match, rsp_data.time_exceeded_match);
                  errors++;
               end
               if (rsp_data.echo_match !== want.echo_match) begin
                  $error("echo_match: expected %0b, got %0b", want.echo_match, rsp_data.echo_match);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_beat(input req_payload_type beat);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
      track_byte(beat);
      bytes_sent++;
   endtask

   task automatic send_span(input int from, input int upto, input logic [31:0] answered);
      req_payload_type beat;
      for (int i = from; i < upto; i++) begin
         beat.data_byte = frame[i];
         beat.last_byte = (i == frame.size() - 1);
         beat.answered_addr = beat.last_byte ? answered : $urandom();
         send_beat(beat);
      end
   endtask

   task automatic send_frame(input logic [31:0] answered);
      send_span(0, frame.size(), answered);
   endtask

   task automatic park_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drain();
      park_req();
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_TARGET_ADDR: cfg_target = data;
         CSR_PROBE_ID:    cfg_id = data[15:0];
         CSR_PROBE_SEQ:   cfg_seq = data[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_probe(input logic [31:0] tgt, input logic [15:0] id, input logic [15:0] seq);
      write_reg(CSR_TARGET_ADDR, tgt);
      write_reg(CSR_PROBE_ID, 32'(id));
      write_reg(CSR_PROBE_SEQ, 32'(seq));
   endtask

   function automatic void put_byte(int pos, logic [7:0] val);
      if (pos < frame.size())
         frame[pos] = val;
   endfunction

   // random bytes; echo and time-exceeded kinds get the type and probe fields for the current settings
   function automatic void make_frame(frame_kind_type kind, int len);
      logic [31:0] idseq;
      idseq = {cfg_id, cfg_seq};
      frame.delete();
      repeat (len) frame.push_back(8'($urandom_range(255)));
      if (kind == FRAME_ECHO) begin
         put_byte(ICMP_OFS, TYPE_ECHO_REPLY);
         for (int k = 0; k < 4; k++)
            put_byte(ECHO_ID_OFS + k, idseq[31 - 8 * k -: 8]);
      end else if (kind == FRAME_TIME_EXC) begin
         put_byte(ICMP_OFS, TYPE_TIME_EXCEEDED);
         put_byte(QTYPE_OFS, TYPE_ECHO_REQUEST);
         for (int k = 0; k < 4; k++) begin
            put_byte(QDEST_OFS + k, cfg_target[31 - 8 * k -: 8]);
            put_byte(QID_OFS + k, idseq[31 - 8 * k -: 8]);
         end
      end
   endfunction

   task automatic test_short_frames();
      wait_drain();
      make_frame(FRAME_NOISE, 1);
      send_frame(cfg_target);
      make_frame(FRAME_NOISE, 20);
      send_frame(cfg_target);
      make_frame(FRAME_ECHO, 21);
      send_frame(cfg_target);
      make_frame(FRAME_ECHO, 27);
      send_frame(cfg_target);
      make_frame(FRAME_ECHO, 28);
      send_frame(cfg_target);
   endtask

   task automatic test_echo_reply();
      wait_drain();
      set_probe(32'hffff_ffff, 16'hffff, 16'hffff);
      make_frame(FRAME_ECHO, 28);
      send_frame(cfg_target);
      make_frame(FRAME_ECHO, 28);
      send_frame(cfg_target ^ 32'h1);
      make_frame(FRAME_ECHO, 28);
      frame[27] ^= 8'h01;
      send_frame(cfg_target);
      make_frame(FRAME_ECHO, 64);
      send_frame(cfg_target);
      make_frame(FRAME_ECHO, 90);
      send_frame(cfg_target);
   endtask

   task automatic test_time_exceeded();
      wait_drain();
      set_probe(32'hc0a8_0101, 16'h1234, 16'h0001);
      make_frame(FRAME_TIME_EXC, 55);
      send_frame($urandom());
      make_frame(FRAME_TIME_EXC, 56);
      send_frame($urandom());
      make_frame(FRAME_TIME_EXC, 56);
      frame[QTYPE_OFS] = TYPE_ECHO_REPLY;
      send_frame($urandom());
      make_frame(FRAME_TIME_EXC, 56);
      frame[QDEST_OFS] ^= 8'h80;
      send_frame($urandom());
      make_frame(FRAME_TIME_EXC, 56);
      frame[QID_OFS + 3] ^= 8'h01;
      send_frame($urandom());
      make_frame(FRAME_TIME_EXC, 100);
      send_frame($urandom());
   endtask

   task automatic test_other_types();
      wait_drain();
      make_frame(FRAME_TIME_EXC, 56);
      frame[ICMP_OFS] = TYPE_ECHO_REQUEST;
      send_frame(cfg_target);
      make_frame(FRAME_ECHO, 40);
      frame[ICMP_OFS] = 8'd3;
      send_frame(cfg_target);
   endtask

   // probe id and target change while a datagram is partly through
   task automatic test_midframe_write();
      wait_drain();
      make_frame(FRAME_ECHO, 30);
      send_span(0, 22, 32'h0);
      park_req();
      write_reg(CSR_PROBE_ID, 32'h0000_a55a);
      frame[ECHO_ID_OFS] = 8'ha5;
      frame[ECHO_ID_OFS + 1] = 8'h5a;
      send_span(22, 29, 32'h0);
      park_req();
      write_reg(CSR_TARGET_ADDR, 32'h0a00_0001);
      send_span(29, 30, 32'h0a00_0001);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [31:0] tgt, input logic [15:0] id,
                                      input logic [15:0] seq);
      int start_bytes;
      int frames;
      int len;
      int pick;
      int spot;
      logic [31:0] answered;
      frame_kind_type kind;
      wait_drain();
      set_probe(tgt, id, seq);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start_bytes = bytes_sent;
      frames = 0;
      while (bytes_sent - start_bytes < 160 || frames < 4) begin
         pick = $urandom_range(99);
         if (pick < 40) kind = FRAME_ECHO;
         else if (pick < 80) kind = FRAME_TIME_EXC;
         else kind = FRAME_NOISE;
         pick = $urandom_range(9);
         case (kind)
            FRAME_ECHO:
               len = (pick == 0) ? $urandom_range(27, 20) :
                     (pick == 1) ? $urandom_range(80, 60) : $urandom_range(40, 28);
            FRAME_TIME_EXC:
               len = (pick == 0) ? $urandom_range(55, 44) :
                     (pick == 1) ? $urandom_range(90, 64) : $urandom_range(62, 56);
            default:
               len = $urandom_range(40, 1);
         endcase
         make_frame(kind, len);
         if ($urandom_range(99) < 30) begin
            spot = SPOT[$urandom_range(13)];
            put_byte(spot, frame[spot % len] ^ 8'($urandom_range(255, 1)));
         end
         pick = $urandom_range(99);
         if (pick < 80) answered = cfg_target;
         else if (pick < 90) answered = cfg_target ^ (32'h1 << $urandom_range(31));
         else answered = $urandom();
         send_frame(answered);
         frames++;
      end
   endtask

   initial begin
      clear_tracker();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_frames();
      test_echo_reply();
      test_time_exceeded();
      test_other_types();
      test_midframe_write();

      test_random_traffic(0, 0, 32'h0, 16'h0, 16'hffff);
      test_random_traffic(53, 0, 32'hffff_ffff, 16'hffff, 16'h0);
      test_random_traffic(0, 53, $urandom(), 16'($urandom()), 16'($urandom()));
      test_random_traffic(19, 19, $urandom(), 16'($urandom()), 16'($urandom()));

      wait_drain();
      repeat (4) @(posedge clock);
      $display("Ran %0d bytes making up %0d datagrams under four idle and stall mixes.",
               bytes_sent, results_seen);
      $display("Saw %0d echo matches and %0d time-exceeded matches.", echo_hits, te_hits);
      if (errors == 0)
         $display("icmp_reply_matcher_tb: clean");
      else
         $display("icmp_reply_matcher_tb: errors");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/icmp_rm_pkg.sv
hdl/icmp_rm_tracker.sv
hdl/icmp_rm_out_reg.sv
hdl/icmp_reply_matcher.sv
verif/icmp_reply_matcher_tb.sv
